>>> sv/scfr_pkg.sv
package scfr_pkg;

    localparam logic [7:0]  SYNC_HI   = 8'hAA;
    localparam logic [7:0]  SYNC_LO   = 8'hBB;
    localparam logic [7:0]  TAIL_HI   = 8'hCC;
    localparam logic [7:0]  TAIL_LO   = 8'hDD;
    localparam logic [15:0] MIN_FRAME = 16'd11;

    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SYNC    = 3'd1,
        ST_LEN     = 3'd2,
        ST_TRAIL   = 3'd3,
        ST_SUM     = 3'd4,
        ST_TIMEOUT = 3'd5
    } t_status;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_payload;
        t_status    status;
        logic [8:0] payload_length;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_res;

endpackage

>>> sv/sum_checked_frame_receiver_unit.sv
// The result register presents a result in the cycle after its byte is accepted.
// Throughput: one input transaction per cycle when the input is not stalled; the state
// update is a single pass from the parser registers to the result register.
// Input is stalled only while a result is held and the output side stalls.
// Reset is synchronous and active low; it clears the parser state and the output valid.
module sum_checked_frame_receiver_unit #(
    parameter int MAX_FRAME = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  scfr_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output scfr_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    logic           accept;
    scfr_pkg::t_res res;
    logic           busy;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    scfr_parser #(
        .MAX_FRAME(MAX_FRAME)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_res    (res)
    );

    scfr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_busy  (busy),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

>>> sv/scfr_parser.sv
module scfr_parser #(
    parameter int MAX_FRAME = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  scfr_pkg::t_in  i_item,
    output scfr_pkg::t_res o_res
);

    localparam int PW = $clog2(MAX_FRAME + 1);
    localparam int LW = (PW > 9) ? PW : 9;

    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_len, n_len;
    logic [7:0]    r_sum, n_sum;
    logic          r_sync, n_sync;
    logic [7:0]    r_prev, n_prev;

    logic [7:0]    sum_b;
    logic [15:0]   len16;
    logic [LW-1:0] plen;

    assign sum_b = r_sum + i_item.rx_byte;
    assign len16 = {r_prev, i_item.rx_byte};
    assign plen  = LW'(r_len) - LW'(scfr_pkg::MIN_FRAME);

    always_comb begin
        logic restart;
        logic advance;
        restart = 1'b0;
        advance = 1'b0;
        n_pos  = r_pos;
        n_len  = r_len;
        n_sum  = r_sum;
        n_sync = r_sync;
        n_prev = r_prev;
        o_res  = '0;
        o_res.data.status = scfr_pkg::ST_OK;

        if (i_item.func == scfr_pkg::FUNC_TIMEOUT) begin
            if (r_pos != '0) begin
                o_res.valid = 1'b1;
                o_res.data.kind = scfr_pkg::KIND_STATUS;
                o_res.data.status = scfr_pkg::ST_TIMEOUT;
                restart = 1'b1;
            end
        end else if (r_pos < PW'(4)) begin
            advance = 1'b1;
            if (r_pos == PW'(0)) begin
                n_sync = (i_item.rx_byte == scfr_pkg::SYNC_HI);
            end else if (r_pos == PW'(1)) begin
                n_sync = r_sync && (i_item.rx_byte == scfr_pkg::SYNC_LO);
            end else if (r_pos == PW'(3)) begin
                if (!r_sync) begin
                    o_res.valid = 1'b1;
                    o_res.data.kind = scfr_pkg::KIND_STATUS;
                    o_res.data.status = scfr_pkg::ST_SYNC;
                    restart = 1'b1;
                    advance = 1'b0;
                end else if (len16 < scfr_pkg::MIN_FRAME || len16 > 16'(MAX_FRAME)) begin
                    o_res.valid = 1'b1;
                    o_res.data.kind = scfr_pkg::KIND_STATUS;
                    o_res.data.status = scfr_pkg::ST_LEN;
                    restart = 1'b1;
                    advance = 1'b0;
                end else begin
                    n_len = len16[PW-1:0];
                end
            end
        end else begin
            if (r_pos >= PW'(8) && r_pos <= r_len - PW'(4)) begin
                o_res.valid = 1'b1;
                o_res.data.kind = scfr_pkg::KIND_PAYLOAD;
                o_res.data.data_byte = i_item.rx_byte;
                o_res.data.last_payload = (r_pos == r_len - PW'(4));
            end
            if (r_pos == r_len - PW'(1)) begin
                o_res.valid = 1'b1;
                o_res.data.kind = scfr_pkg::KIND_STATUS;
                o_res.data.payload_length = plen[8:0];
                if (r_prev != scfr_pkg::TAIL_HI || i_item.rx_byte != scfr_pkg::TAIL_LO) begin
                    o_res.data.status = scfr_pkg::ST_TRAIL;
                end else if (sum_b != 8'd0) begin
                    o_res.data.status = scfr_pkg::ST_SUM;
                end else begin
                    o_res.data.status = scfr_pkg::ST_OK;
                end
                restart = 1'b1;
            end else begin
                advance = 1'b1;
            end
        end

        if (advance) begin
            n_sum  = sum_b;
            n_prev = i_item.rx_byte;
            n_pos  = r_pos + PW'(1);
        end
        if (restart) begin
            n_pos  = '0;
            n_len  = '0;
            n_sum  = '0;
            n_sync = 1'b1;
            n_prev = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_sum  <= '0;
            r_sync <= 1'b1;
            r_prev <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_sum  <= n_sum;
            r_sync <= n_sync;
            r_prev <= n_prev;
        end
    end

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos >= PW'(4) |-> (PW'(11) <= r_len) && (16'(r_len) <= 16'(MAX_FRAME)))
        else $error("frame length out of range inside a frame");

    a_timeout_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.func == scfr_pkg::FUNC_TIMEOUT && r_pos != '0
        |=> r_pos == '0 && r_sum == 8'd0 && r_sync)
        else $error("timeout did not restart parsing");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.func == scfr_pkg::FUNC_BYTE
        && !(o_res.valid && o_res.data.kind == scfr_pkg::KIND_STATUS)
        |=> r_pos == $past(r_pos) + PW'(1))
        else $error("byte position did not advance");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos >= PW'(4) |-> r_pos < r_len)
        else $error("byte position passed the frame end");

endmodule

>>> sv/scfr_out_reg.sv
module scfr_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  scfr_pkg::t_res i_res,
    input  logic           i_stall,
    output logic           o_busy,
    output logic           o_valid,
    output scfr_pkg::t_out o_data
);

    logic           r_valid;
    scfr_pkg::t_out r_data;

    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_busy) begin
            r_valid <= i_load && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_busy && i_load && i_res.valid) begin
            r_data <= i_res.data;
        end
    end

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LIMIT  = 512;
    localparam int RANDOM_ITEMS = 1800;

    class deframer_scoreboard;
        scfr_pkg::t_out deframed_q[$];
        int             errors;
        bit [9:0]       rx_pos;
        bit [15:0]      rx_len;
        bit [7:0]       rx_sum;
        bit             sync_good;
        bit [7:0]       rx_prev;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            rx_pos    = '0;
            rx_len    = '0;
            rx_sum    = '0;
            sync_good = 1'b1;
            rx_prev   = '0;
        endfunction

        function void push_status(scfr_pkg::t_status st, logic [8:0] plen);
            scfr_pkg::t_out r;
            r.kind           = scfr_pkg::KIND_STATUS;
            r.data_byte      = '0;
            r.last_payload   = 1'b0;
            r.status         = st;
            r.payload_length = plen;
            deframed_q.push_back(r);
        endfunction

        function int pending();
            return deframed_q.size();
        endfunction

        // Notes one accepted input transaction and predicts what it causes.
        function void note_rx(scfr_pkg::t_in x);
            scfr_pkg::t_out    r;
            scfr_pkg::t_status st;
            logic [7:0]        b;
            if (x.func == scfr_pkg::FUNC_TIMEOUT) begin
                if (rx_pos != 0) begin
                    push_status(scfr_pkg::ST_TIMEOUT, '0);
                    clear_frame();
                end
                return;
            end
            b = x.rx_byte;
            rx_sum = rx_sum + b;
            if (rx_pos < 4) begin
                if (rx_pos == 0) begin
                    sync_good = (b == scfr_pkg::SYNC_HI);
                end else if (rx_pos == 1) begin
                    sync_good = sync_good && (b == scfr_pkg::SYNC_LO);
                end
                if (rx_pos == 3) begin
                    rx_len = {rx_prev, b};
                    if (!sync_good) begin
                        push_status(scfr_pkg::ST_SYNC, '0);
                        clear_frame();
                        return;
                    end
                    if (rx_len < scfr_pkg::MIN_FRAME || rx_len > 16'(FRAME_LIMIT)) begin
                        push_status(scfr_pkg::ST_LEN, '0);
                        clear_frame();
                        return;
                    end
                end
                rx_prev = b;
                rx_pos  = rx_pos + 10'd1;
                return;
            end
            if (rx_pos >= 8 && 16'(rx_pos) <= rx_len - 16'd4) begin
                r.kind           = scfr_pkg::KIND_PAYLOAD;
                r.data_byte      = b;
                r.last_payload   = (16'(rx_pos) == rx_len - 16'd4);
                r.status         = scfr_pkg::ST_OK;
                r.payload_length = '0;
                deframed_q.push_back(r);
            end
            if (16'(rx_pos) + 16'd1 >= rx_len) begin
                if (rx_prev != scfr_pkg::TAIL_HI || b != scfr_pkg::TAIL_LO) begin
                    st = scfr_pkg::ST_TRAIL;
                end else if (rx_sum != 0) begin
                    st = scfr_pkg::ST_SUM;
                end else begin
                    st = scfr_pkg::ST_OK;
                end
                push_status(st, 9'(rx_len - scfr_pkg::MIN_FRAME));
                clear_frame();
                return;
            end
            rx_prev = b;
            rx_pos  = rx_pos + 10'd1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(scfr_pkg::t_out got);
            scfr_pkg::t_out want;
            if (deframed_q.size() == 0) begin
                $error("unexpected result transaction: kind %0d status %0d data %0d",
                       got.kind, got.status, got.data_byte);
                errors++;
                return;
            end
            want = deframed_q.pop_front();
            compare_field("kind", 16'(want.kind), 16'(got.kind));
            compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            compare_field("last_payload", 16'(want.last_payload), 16'(got.last_payload));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("payload_length", 16'(want.payload_length),
                          16'(got.payload_length));
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    scfr_pkg::t_in  i_in_data   = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    scfr_pkg::t_out o_out_data;

    deframer_scoreboard sb;
    scfr_pkg::t_in stim_q[$];
    int  stall_mode  = 0;
    int  stall_count = 0;

    sum_checked_frame_receiver_unit #(
        .MAX_FRAME(FRAME_LIMIT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_count == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_count <= $urandom_range(20, 300);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= ((stall_count % 5) < 2);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_rx(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
            end
        end
    end

    function automatic void push_byte(logic [7:0] b);
        stim_q.push_back('{func: scfr_pkg::FUNC_BYTE, rx_byte: b});
    endfunction

    function automatic void push_timeout();
        stim_q.push_back('{func: scfr_pkg::FUNC_TIMEOUT,
                           rx_byte: 8'($urandom_range(0, 255))});
    endfunction

    // Bit 0 of flaw corrupts the first sync byte, bit 1 the second.
    function automatic void add_header(logic [15:0] len, int flaw);
        push_byte(flaw[0] ? scfr_pkg::SYNC_HI ^ 8'($urandom_range(1, 255))
                          : scfr_pkg::SYNC_HI);
        push_byte(flaw[1] ? scfr_pkg::SYNC_LO ^ 8'($urandom_range(1, 255))
                          : scfr_pkg::SYNC_LO);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
    endfunction

    // A negative cut sends the whole frame; otherwise the first cut bytes and a timeout.
    function automatic void add_frame(int len, bit bad_sum, bit bad_tail, int cut);
        logic [7:0]  fr[$];
        logic [7:0]  s;
        logic [7:0]  tail_hi;
        logic [7:0]  tail_lo;
        logic [15:0] l16;
        int          which;
        l16 = 16'(len);
        fr.push_back(scfr_pkg::SYNC_HI);
        fr.push_back(scfr_pkg::SYNC_LO);
        fr.push_back(l16[15:8]);
        fr.push_back(l16[7:0]);
        for (int k = 4; k < len - 3; k++) begin
            fr.push_back(8'($urandom_range(0, 255)));
        end
        tail_hi = scfr_pkg::TAIL_HI;
        tail_lo = scfr_pkg::TAIL_LO;
        if (bad_tail) begin
            which = $urandom_range(0, 2);
            if (which != 1) begin
                tail_hi = tail_hi ^ 8'($urandom_range(1, 255));
            end
            if (which != 0) begin
                tail_lo = tail_lo ^ 8'($urandom_range(1, 255));
            end
        end
        s = tail_hi + tail_lo;
        foreach (fr[k]) begin
            s = s + fr[k];
        end
        s = 8'h00 - s;
        if (bad_sum) begin
            s = s + 8'($urandom_range(1, 255));
        end
        fr.push_back(s);
        fr.push_back(tail_hi);
        fr.push_back(tail_lo);
        if (cut < 0) begin
            foreach (fr[k]) begin
                push_byte(fr[k]);
            end
        end else begin
            for (int k = 0; k < cut; k++) begin
                push_byte(fr[k]);
            end
            push_timeout();
        end
    endfunction

    task automatic send_item(scfr_pkg::t_in x);
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic pause_input(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            i_in_data  <= scfr_pkg::t_in'($urandom_range(0, 511));
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int pick;
        int len;
        int flaw;
        int burst_left;
        int directed_items;
        bit first_frame;
        sb = new();

        push_timeout();
        add_header(16'd12, 1);
        add_header(16'd10, 0);
        add_header(16'(FRAME_LIMIT + 1), 0);
        add_frame(11, 1'b0, 1'b0, -1);
        add_frame(11, 1'b0, 1'b0, 2);
        directed_items = stim_q.size();

        first_frame = 1'b1;
        while (stim_q.size() < directed_items + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pick = $urandom_range(0, 99);
                if (first_frame) begin
                    len = FRAME_LIMIT;
                end else if (pick < 50) begin
                    len = $urandom_range(11, 20);
                end else if (pick < 85) begin
                    len = $urandom_range(21, 60);
                end else if (pick < 97) begin
                    len = $urandom_range(61, 200);
                end else begin
                    len = ($urandom_range(0, 1) == 0) ? FRAME_LIMIT
                                                      : $urandom_range(11, FRAME_LIMIT);
                end
                first_frame = 1'b0;
                flaw = $urandom_range(0, 19);
                case (flaw)
                    0, 1: begin
                        add_frame(len, 1'b1, 1'b0, -1);
                    end
                    2, 3: begin
                        add_frame(len, 1'b0, 1'b1, -1);
                    end
                    4: begin
                        add_frame(len, 1'b1, 1'b1, -1);
                    end
                    5, 6: begin
                        add_frame(len, 1'b0, 1'b0, $urandom_range(0, len - 1));
                    end
                    default: begin
                        add_frame(len, 1'b0, 1'b0, -1);
                    end
                endcase
            end else if (pick < 85) begin
                flaw = $urandom_range(0, 3);
                if (flaw == 0) begin
                    len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 10)
                                                      : $urandom_range(FRAME_LIMIT + 1, 65535);
                end else begin
                    len = $urandom_range(0, 65535);
                end
                add_header(16'(len), flaw);
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 8)) begin
                    stim_q.push_back('{func: ($urandom_range(0, 3) == 0),
                                       rx_byte: 8'($urandom_range(0, 255))});
                end
                push_timeout();
            end else begin
                push_timeout();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(1, 30);
        foreach (stim_q[k]) begin
            send_item(stim_q[k]);
            burst_left--;
            if (burst_left == 0) begin
                pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 12);
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
